@@ sv/tbfc_pkg.sv @@
package tbfc_pkg;

    localparam int HEADER_BYTES_DEF = 7;
    localparam int COUNT_BITS_DEF   = 32;
    localparam int QUEUE_DEPTH      = 2;

    localparam int SIG_POS   = 7;
    localparam int SIG_COUNT = 14;

    localparam logic [3:0] TYPE_NONE    = 4'd0;
    localparam logic [3:0] TYPE_PAK     = 4'd1;
    localparam logic [3:0] TYPE_GZIP    = 4'd2;
    localparam logic [3:0] TYPE_COMPR   = 4'd3;
    localparam logic [3:0] TYPE_ARJ     = 4'd4;
    localparam logic [3:0] TYPE_HYPER   = 4'd5;
    localparam logic [3:0] TYPE_GIF     = 4'd6;
    localparam logic [3:0] TYPE_HPACK   = 4'd7;
    localparam logic [3:0] TYPE_ZIP     = 4'd8;
    localparam logic [3:0] TYPE_ZOO     = 4'd9;
    localparam logic [3:0] TYPE_LZH     = 4'd10;
    localparam logic [3:0] TYPE_LHA     = 4'd11;
    localparam logic [3:0] TYPE_OPENPGP = 4'd12;

    localparam logic [7:0] CTRL_LOW_END  = 8'd7;
    localparam logic [7:0] CTRL_HIGH_END = 8'd13;
    localparam logic [7:0] CTRL_EOF      = 8'd26;
    localparam logic [7:0] CTRL_LIMIT    = 8'd32;

    localparam logic [1:0] OPENPGP_LEAD = 2'b10;
    localparam int         OPENPGP_HLEN = 5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [3:0] file_type;
        logic       is_binary;
    } t_out_item;

    typedef struct packed {
        logic [2:0]               len;
        logic [SIG_POS-1:0]       care;
        logic [0:SIG_POS-1][7:0]  val;
        logic [3:0]               code;
    } t_sig;

    localparam t_sig SIG_TABLE [0:SIG_COUNT-1] = '{
        '{len: 3'd2, care: 7'h03, val: '{8'd26, 8'd11, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
          code: TYPE_PAK},
        '{len: 3'd2, care: 7'h03, val: '{8'd31, 8'd139, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
          code: TYPE_GZIP},
        '{len: 3'd2, care: 7'h03, val: '{8'd31, 8'd157, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
          code: TYPE_COMPR},
        '{len: 3'd2, care: 7'h03, val: '{8'd234, 8'd96, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
          code: TYPE_ARJ},
        '{len: 3'd4, care: 7'h0F, val: '{8'd26, 8'd72, 8'd80, 8'd37, 8'd0, 8'd0, 8'd0},
          code: TYPE_HYPER},
        '{len: 3'd4, care: 7'h0F, val: '{8'd71, 8'd73, 8'd70, 8'd56, 8'd0, 8'd0, 8'd0},
          code: TYPE_GIF},
        '{len: 3'd4, care: 7'h0F, val: '{8'd72, 8'd80, 8'd65, 8'd75, 8'd0, 8'd0, 8'd0},
          code: TYPE_HPACK},
        '{len: 3'd4, care: 7'h0F, val: '{8'd80, 8'd75, 8'd3, 8'd4, 8'd0, 8'd0, 8'd0},
          code: TYPE_ZIP},
        '{len: 3'd4, care: 7'h0F, val: '{8'd90, 8'd79, 8'd79, 8'd32, 8'd0, 8'd0, 8'd0},
          code: TYPE_ZOO},
        '{len: 3'd7, care: 7'h7C, val: '{8'd0, 8'd0, 8'd45, 8'd108, 8'd104, 8'd48, 8'd45},
          code: TYPE_LZH},
        '{len: 3'd7, care: 7'h7C, val: '{8'd0, 8'd0, 8'd45, 8'd108, 8'd104, 8'd49, 8'd45},
          code: TYPE_LZH},
        '{len: 3'd7, care: 7'h7C, val: '{8'd0, 8'd0, 8'd45, 8'd108, 8'd104, 8'd50, 8'd45},
          code: TYPE_LZH},
        '{len: 3'd7, care: 7'h7C, val: '{8'd0, 8'd0, 8'd45, 8'd108, 8'd104, 8'd51, 8'd45},
          code: TYPE_LZH},
        '{len: 3'd7, care: 7'h5C, val: '{8'd0, 8'd0, 8'd45, 8'd108, 8'd104, 8'd0, 8'd45},
          code: TYPE_LHA}
    };

    localparam logic [0:OPENPGP_HLEN-1][7:0] OPENPGP_HEAD =
        '{8'd168, 8'd3, 8'd80, 8'd71, 8'd80};

    // Old-format packet tags that count as a recognized packet.
    function automatic logic openpgp_tag_ok(input logic [3:0] tag);
        logic ok;
        case (tag) inside
            4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd11, 4'd14: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

@@ sv/tbfc_front.sv @@
module tbfc_front #(
    parameter int HEADER_BYTES = tbfc_pkg::HEADER_BYTES_DEF,
    parameter int COUNT_BITS   = tbfc_pkg::COUNT_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_accept,
    input  tbfc_pkg::t_in_item                      i_in,
    output logic                                    o_rec_push,
    output logic [HEADER_BYTES*8+2*COUNT_BITS:0]    o_rec
);

    localparam int IDX_W = $clog2(HEADER_BYTES);

    typedef struct packed {
        logic [HEADER_BYTES-1:0][7:0] hdr;
        logic [COUNT_BITS-1:0]        count;
        logic [COUNT_BITS-1:0]        high;
        logic                         ill;
    } t_rec;

    logic [HEADER_BYTES-1:0][7:0] r_hdr, n_hdr;
    logic [COUNT_BITS-1:0]        r_count, n_count;
    logic [COUNT_BITS-1:0]        r_high, n_high;
    logic                         r_ill, n_ill;
    logic                         byte_illegal;
    t_rec                         rec;

    assign byte_illegal = (i_in.data_byte < tbfc_pkg::CTRL_LIMIT)
                       && ((i_in.data_byte < tbfc_pkg::CTRL_LOW_END)
                           || (i_in.data_byte > tbfc_pkg::CTRL_HIGH_END))
                       && (i_in.data_byte != tbfc_pkg::CTRL_EOF);

    always_comb begin
        n_hdr   = r_hdr;
        n_count = r_count;
        n_high  = r_high;
        n_ill   = r_ill;
        if (r_count < COUNT_BITS'(HEADER_BYTES)) begin
            n_hdr[r_count[IDX_W-1:0]] = i_in.data_byte;
        end
        if (r_count != '1) begin
            n_count = r_count + 1'b1;
        end
        if (i_in.data_byte[7] && (r_high != '1)) begin
            n_high = r_high + 1'b1;
        end
        if (byte_illegal) begin
            n_ill = 1'b1;
        end
    end

    // The closing byte itself is part of the record handed to the back end.
    assign rec.hdr   = n_hdr;
    assign rec.count = n_count;
    assign rec.high  = n_high;
    assign rec.ill   = n_ill;
    assign o_rec      = rec;
    assign o_rec_push = i_accept && i_in.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_high  <= '0;
            r_ill   <= 1'b0;
        end else if (i_accept) begin
            if (i_in.last) begin
                r_count <= '0;
                r_high  <= '0;
                r_ill   <= 1'b0;
            end else begin
                r_count <= n_count;
                r_high  <= n_high;
                r_ill   <= n_ill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_hdr <= n_hdr;
        end
    end

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rec_push |=> (r_count == '0) && (r_high == '0) && !r_ill)
        else $error("buffer state not cleared after closing item");

    a_high_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_high <= r_count)
        else $error("high-bit count exceeds byte count");

endmodule

@@ sv/tbfc_queue.sv @@
module tbfc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tbfc_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             do_wr, do_rd;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_cnt_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_wr && !do_rd) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count did not follow a write");

endmodule

@@ sv/tbfc_back.sv @@
module tbfc_back #(
    parameter int HEADER_BYTES = tbfc_pkg::HEADER_BYTES_DEF,
    parameter int COUNT_BITS   = tbfc_pkg::COUNT_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic [HEADER_BYTES*8+2*COUNT_BITS:0]    i_rec,
    input  logic                                    i_rec_empty,
    output logic                                    o_rec_rd,
    input  logic                                    i_cfg_we,
    input  logic                                    i_cfg_data,
    input  logic                                    i_pop,
    output logic                                    o_empty,
    output tbfc_pkg::t_out_item                     o_out
);

    typedef struct packed {
        logic [HEADER_BYTES-1:0][7:0] hdr;
        logic [COUNT_BITS-1:0]        count;
        logic [COUNT_BITS-1:0]        high;
        logic                         ill;
    } t_rec;

    t_rec                              rec;
    logic [tbfc_pkg::SIG_COUNT-1:0]    sig_hit;
    logic                              pgp_hit;
    logic                              pgp_head_ok;
    logic                              high_over;
    logic [3:0]                        n_type;
    tbfc_pkg::t_out_item               n_out;
    tbfc_pkg::t_out_item               r_out;
    logic                              r_out_valid;
    logic                              r_cyrillic;

    assign rec = i_rec;

    always_comb begin
        for (int i = 0; i < tbfc_pkg::SIG_COUNT; i++) begin
            sig_hit[i] = (rec.count >= COUNT_BITS'(tbfc_pkg::SIG_TABLE[i].len));
            for (int j = 0; j < tbfc_pkg::SIG_POS; j++) begin
                if (tbfc_pkg::SIG_TABLE[i].care[j]
                    && (rec.hdr[j] != tbfc_pkg::SIG_TABLE[i].val[j])) begin
                    sig_hit[i] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        pgp_head_ok = (rec.count >= COUNT_BITS'(tbfc_pkg::OPENPGP_HLEN));
        for (int j = 0; j < tbfc_pkg::OPENPGP_HLEN; j++) begin
            if (rec.hdr[j] != tbfc_pkg::OPENPGP_HEAD[j]) begin
                pgp_head_ok = 1'b0;
            end
        end
        pgp_hit = (rec.count != '0)
               && (rec.hdr[0][7:6] == tbfc_pkg::OPENPGP_LEAD)
               && (pgp_head_ok || tbfc_pkg::openpgp_tag_ok(rec.hdr[0][5:2]));
    end

    // Walk from the bottom of the table so that the earliest hit wins.
    always_comb begin
        n_type = tbfc_pkg::TYPE_NONE;
        if (pgp_hit) begin
            n_type = tbfc_pkg::TYPE_OPENPGP;
        end
        for (int i = tbfc_pkg::SIG_COUNT - 1; i >= 0; i--) begin
            if (sig_hit[i]) begin
                n_type = tbfc_pkg::SIG_TABLE[i].code;
            end
        end
    end

    assign high_over       = rec.high > (rec.count >> 2);
    assign n_out.file_type = n_type;
    assign n_out.is_binary = (n_type != tbfc_pkg::TYPE_NONE) || rec.ill
                          || (!r_cyrillic && high_over);

    assign o_rec_rd = !i_rec_empty && (!r_out_valid || i_pop);
    assign o_empty  = !r_out_valid;
    assign o_out    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cyrillic  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cyrillic <= i_cfg_data;
            end
            if (o_rec_rd) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rec_rd) begin
            r_out <= n_out;
        end
    end

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rec_rd |=> r_out_valid)
        else $error("classified item not presented after load");

    a_known_is_binary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.file_type != tbfc_pkg::TYPE_NONE)) |-> r_out.is_binary)
        else $error("recognized type reported as text");

endmodule

@@ sv/text_binary_file_classifier.sv @@
// Accepts one byte per cycle with no stalls while the result path keeps up.
// The edge that accepts a buffer's last byte closes it into the record queue;
// a later edge classifies it into the output register once that register is
// empty or being popped. Two closed buffers can wait in the queue.
// Reset is synchronous: counts, flags, queue, output and the mode register
// clear; the kept header bytes are not reset.
module text_binary_file_classifier #(
    parameter int HEADER_BYTES = tbfc_pkg::HEADER_BYTES_DEF,
    parameter int COUNT_BITS   = tbfc_pkg::COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  tbfc_pkg::t_in_item    i_in,
    output logic                  empty,
    input  logic                  pop,
    output tbfc_pkg::t_out_item   o_out,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_data
);

    localparam int REC_W = HEADER_BYTES * 8 + 2 * COUNT_BITS + 1;

    logic             accept;
    logic             rec_push;
    logic [REC_W-1:0] rec_in;
    logic [REC_W-1:0] rec_out;
    logic             rec_full;
    logic             rec_empty;
    logic             rec_rd;

    assign full   = rec_full;
    assign accept = push && !rec_full;

    tbfc_front #(
        .HEADER_BYTES (HEADER_BYTES),
        .COUNT_BITS   (COUNT_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_in       (i_in),
        .o_rec_push (rec_push),
        .o_rec      (rec_in)
    );

    tbfc_queue #(
        .WIDTH (REC_W),
        .DEPTH (tbfc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (rec_push),
        .i_wdata (rec_in),
        .o_full  (rec_full),
        .i_rd    (rec_rd),
        .o_rdata (rec_out),
        .o_empty (rec_empty)
    );

    tbfc_back #(
        .HEADER_BYTES (HEADER_BYTES),
        .COUNT_BITS   (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (rec_out),
        .i_rec_empty (rec_empty),
        .o_rec_rd    (rec_rd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out       (o_out)
    );

endmodule

@@ bench/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tbfc_pkg::*;

    localparam int HDR_LEN     = 7;
    // Narrow counters, so that long buffers drive the byte count into saturation.
    localparam int CNT_W       = 8;
    localparam int MAGIC_COUNT = 14;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_ITEMS = 265;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [2:0]       len;
        logic [6:0]       care;
        logic [0:6][7:0]  val;
        logic [3:0]       code;
    } t_magic;

    localparam t_magic MAGIC [0:MAGIC_COUNT-1] = '{
        '{3'd2, 7'h03, '{8'd26, 8'd11, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, TYPE_PAK},
        '{3'd2, 7'h03, '{8'd31, 8'd139, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, TYPE_GZIP},
        '{3'd2, 7'h03, '{8'd31, 8'd157, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, TYPE_COMPR},
        '{3'd2, 7'h03, '{8'd234, 8'd96, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, TYPE_ARJ},
        '{3'd4, 7'h0F, '{8'd26, 8'd72, 8'd80, 8'd37, 8'd0, 8'd0, 8'd0}, TYPE_HYPER},
        '{3'd4, 7'h0F, '{8'd71, 8'd73, 8'd70, 8'd56, 8'd0, 8'd0, 8'd0}, TYPE_GIF},
        '{3'd4, 7'h0F, '{8'd72, 8'd80, 8'd65, 8'd75, 8'd0, 8'd0, 8'd0}, TYPE_HPACK},
        '{3'd4, 7'h0F, '{8'd80, 8'd75, 8'd3, 8'd4, 8'd0, 8'd0, 8'd0}, TYPE_ZIP},
        '{3'd4, 7'h0F, '{8'd90, 8'd79, 8'd79, 8'd32, 8'd0, 8'd0, 8'd0}, TYPE_ZOO},
        '{3'd7, 7'h7C, '{8'd0, 8'd0, 8'd45, 8'd108, 8'd104, 8'd48, 8'd45}, TYPE_LZH},
        '{3'd7, 7'h7C, '{8'd0, 8'd0, 8'd45, 8'd108, 8'd104, 8'd49, 8'd45}, TYPE_LZH},
        '{3'd7, 7'h7C, '{8'd0, 8'd0, 8'd45, 8'd108, 8'd104, 8'd50, 8'd45}, TYPE_LZH},
        '{3'd7, 7'h7C, '{8'd0, 8'd0, 8'd45, 8'd108, 8'd104, 8'd51, 8'd45}, TYPE_LZH},
        '{3'd7, 7'h5C, '{8'd0, 8'd0, 8'd45, 8'd108, 8'd104, 8'd0, 8'd45}, TYPE_LHA}
    };

    localparam logic [0:4][7:0] PGP_HEAD_BYTES = '{8'd168, 8'd3, 8'd80, 8'd71, 8'd80};

    typedef struct packed {
        logic [7:0] b;
        logic       lst;
        logic       typed;
        logic [3:0] ft;
        logic       bin;
    } t_row;

    localparam t_row DIRECTED [0:24] = '{
        '{8'd31,  1'b0, 1'b0, TYPE_NONE,    1'b0},
        '{8'd139, 1'b1, 1'b1, TYPE_GZIP,    1'b1},
        '{8'd255, 1'b1, 1'b1, TYPE_NONE,    1'b1},
        '{8'd0,   1'b1, 1'b1, TYPE_NONE,    1'b1},
        '{8'd65,  1'b1, 1'b1, TYPE_NONE,    1'b0},
        '{8'd168, 1'b0, 1'b0, TYPE_NONE,    1'b0},
        '{8'd3,   1'b0, 1'b0, TYPE_NONE,    1'b0},
        '{8'd80,  1'b0, 1'b0, TYPE_NONE,    1'b0},
        '{8'd71,  1'b0, 1'b0, TYPE_NONE,    1'b0},
        '{8'd80,  1'b1, 1'b1, TYPE_OPENPGP, 1'b1},
        '{8'd132, 1'b1, 1'b1, TYPE_OPENPGP, 1'b1},
        '{8'd0,   1'b0, 1'b0, TYPE_NONE,    1'b0},
        '{8'd0,   1'b0, 1'b0, TYPE_NONE,    1'b0},
        '{8'd45,  1'b0, 1'b0, TYPE_NONE,    1'b0},
        '{8'd108, 1'b0, 1'b0, TYPE_NONE,    1'b0},
        '{8'd104, 1'b0, 1'b0, TYPE_NONE,    1'b0},
        '{8'd53,  1'b0, 1'b0, TYPE_NONE,    1'b0},
        '{8'd45,  1'b1, 1'b1, TYPE_LHA,     1'b1},
        '{8'd90,  1'b0, 1'b0, TYPE_NONE,    1'b0},
        '{8'd79,  1'b0, 1'b0, TYPE_NONE,    1'b0},
        '{8'd79,  1'b0, 1'b0, TYPE_NONE,    1'b0},
        '{8'd32,  1'b1, 1'b0, TYPE_NONE,    1'b0},
        '{8'd26,  1'b0, 1'b0, TYPE_NONE,    1'b0},
        '{8'd9,   1'b0, 1'b0, TYPE_NONE,    1'b0},
        '{8'd200, 1'b1, 1'b0, TYPE_NONE,    1'b0}
    };

    logic       i_clk;
    logic       i_rst_n    = 1'b0;
    logic       push       = 1'b0;
    logic       full;
    t_in_item   i_in       = '0;
    logic       empty;
    logic       pop        = 1'b0;
    t_out_item  o_out;
    logic       i_cfg_we   = 1'b0;
    logic       i_cfg_data = 1'b0;

    // Predictor state for the buffer being collected.
    logic [7:0]       kept_hdr [0:HDR_LEN-1] = '{default: 8'd0};
    logic [CNT_W-1:0] seen_bytes  = '0;
    logic [CNT_W-1:0] seen_high   = '0;
    logic             saw_illegal = 1'b0;
    logic             mode_now    = 1'b0;

    t_out_item verdict_q [$];
    int        bad_count    = 0;
    int        stall_cycles = 0;
    int        n_fed        = 0;
    bit        calm         = 1'b0;

    text_binary_file_classifier #(
        .HEADER_BYTES(HDR_LEN),
        .COUNT_BITS(CNT_W)
    ) uut (
        .i_clk,
        .i_rst_n,
        .push,
        .full,
        .i_in,
        .empty,
        .pop,
        .o_out,
        .i_cfg_we,
        .i_cfg_data
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Folds one byte into the buffer state; on the closing byte it returns the verdict.
    function automatic t_out_item absorb_byte(input logic [7:0] b, input logic lst);
        t_out_item v;
        logic      hit;
        logic      head_ok;
        v = '0;
        if (seen_bytes < HDR_LEN) kept_hdr[seen_bytes] = b;
        if (seen_bytes != COUNT_MAX) seen_bytes++;
        if (b[7] && seen_high != COUNT_MAX) seen_high++;
        if (b < CTRL_LIMIT && (b < CTRL_LOW_END || b > CTRL_HIGH_END) && b != CTRL_EOF) begin
            saw_illegal = 1'b1;
        end
        if (!lst) return v;

        v.file_type = TYPE_NONE;
        for (int s = 0; s < MAGIC_COUNT; s++) begin
            hit = (seen_bytes >= MAGIC[s].len);
            for (int p = 0; p < HDR_LEN; p++) begin
                if (hit && p < MAGIC[s].len && MAGIC[s].care[p] && kept_hdr[p] != MAGIC[s].val[p])
                    hit = 1'b0;
            end
            if (hit && v.file_type == TYPE_NONE) v.file_type = MAGIC[s].code;
        end
        if (v.file_type == TYPE_NONE && seen_bytes != 0 && kept_hdr[0][7:6] == OPENPGP_LEAD) begin
            head_ok = (seen_bytes >= 5);
            for (int p = 0; p < 5; p++) begin
                if (head_ok && kept_hdr[p] != PGP_HEAD_BYTES[p]) head_ok = 1'b0;
            end
            if (head_ok) begin
                v.file_type = TYPE_OPENPGP;
            end else begin
                case (kept_hdr[0][5:2])
                    4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd11, 4'd14: begin
                        v.file_type = TYPE_OPENPGP;
                    end
                    default: ;
                endcase
            end
        end
        v.is_binary = (v.file_type != TYPE_NONE) || saw_illegal
                      || (!mode_now && seen_high > (seen_bytes >> 2));
        seen_bytes  = '0;
        seen_high   = '0;
        saw_illegal = 1'b0;
        return v;
    endfunction

    // Mostly printable text, with allowed controls, high-bit bytes and the odd bad control.
    function automatic logic [7:0] text_byte();
        int p;
        int r;
        p = $urandom_range(0, 99);
        if (p < 68) return 8'($urandom_range(32, 126));
        if (p < 80) begin
            r = $urandom_range(7, 14);
            return (r == 14) ? CTRL_EOF : 8'(r);
        end
        if (p < 97) return 8'($urandom_range(128, 255));
        return 8'($urandom_range(0, 31));
    endfunction

    task automatic feed(input logic [7:0] b, input logic lst, input logic typed,
                        input t_out_item typed_out);
        t_out_item v;
        if (!calm && $urandom_range(0, 99) < 30) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_in <= '{data_byte: b, last: lst};
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        v = absorb_byte(b, lst);
        if (lst) verdict_q.push_back(typed ? typed_out : v);
        n_fed++;
    endtask

    task automatic random_buffer(input bit go_long);
        logic [7:0] bytes [$];
        logic [7:0] b;
        int         pick;
        int         len;
        int         s;
        int         hi_pct;
        pick = $urandom_range(0, 99);
        if (go_long) begin
            len    = $urandom_range(260, 300);
            hi_pct = $urandom_range(0, 60);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 99) < hi_pct) b = 8'($urandom_range(128, 255));
                else b = 8'($urandom_range(32, 126));
                bytes.push_back(b);
            end
        end else if (pick < 35) begin
            // Signature with random wildcard content, sometimes cut short.
            s   = $urandom_range(0, MAGIC_COUNT - 1);
            len = MAGIC[s].len + $urandom_range(0, 5);
            if ($urandom_range(0, 99) < 15) len = $urandom_range(1, MAGIC[s].len);
            for (int i = 0; i < len; i++) begin
                b = text_byte();
                if (i < HDR_LEN && MAGIC[s].care[i]) b = MAGIC[s].val[i];
                else if (i == 5 && $urandom_range(0, 1)) b = 8'd48 + 8'($urandom_range(0, 7));
                bytes.push_back(b);
            end
        end else if (pick < 50) begin
            len = $urandom_range(1, 9);
            if ($urandom_range(0, 1)) begin
                for (int i = 0; i < len; i++) bytes.push_back(i < 5 ? PGP_HEAD_BYTES[i] : text_byte());
            end else begin
                bytes.push_back({OPENPGP_LEAD, 6'($urandom_range(0, 63))});
                for (int i = 1; i < len; i++) bytes.push_back(8'($urandom_range(0, 255)));
            end
        end else if (pick < 85) begin
            len = $urandom_range(1, 16);
            for (int i = 0; i < len; i++) bytes.push_back(text_byte());
        end else begin
            len = $urandom_range(1, 10);
            for (int i = 0; i < len; i++) bytes.push_back(8'($urandom_range(0, 255)));
        end
        foreach (bytes[i]) feed(bytes[i], i == bytes.size() - 1, 1'b0, '0);
    endtask

    // The mode register is only written once the block has drained.
    task automatic set_mode(input logic m);
        push <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mode_now = m;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (DIRECTED[r]) begin
            feed(DIRECTED[r].b, DIRECTED[r].lst, DIRECTED[r].typed,
                 '{file_type: DIRECTED[r].ft, is_binary: DIRECTED[r].bin});
        end
        for (int ph = 0; ph < 5; ph++) begin
            set_mode(ph % 2 == 0);
            calm  = (ph == 2);
            n_fed = 0;
            if (ph == 1 || ph == 3) random_buffer(1'b1);
            while (n_fed < PHASE_ITEMS) random_buffer(1'b0);
        end
        push <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (bad_count == 0 && verdict_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && pop && !empty) begin
            if (verdict_q.size() == 0) begin
                bad_count++;
                if (bad_count <= 10)
                    $display("result with nothing expected: type %0d binary %0d",
                             o_out.file_type, o_out.is_binary);
            end else begin
                want = verdict_q.pop_front();
                if (o_out.file_type !== want.file_type || o_out.is_binary !== want.is_binary) begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("mismatch: type %0d/%0d binary %0d/%0d (expected/actual)",
                                 want.file_type, o_out.file_type, want.is_binary,
                                 o_out.is_binary);
                end
            end
        end
        pop <= calm || ($urandom_range(0, 99) >= 31);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

@@ filelist.f @@
sv/tbfc_pkg.sv
sv/tbfc_front.sv
sv/tbfc_queue.sv
sv/tbfc_back.sv
sv/text_binary_file_classifier.sv
bench/tb_top.sv
